### hdl/tip_pkg.sv
// Shared widths, payload types and status codes of the intercept predictor.
package tip_pkg;

  // Fixed-point widths of the solver datapath
  localparam int RW   = 33;          // target minus muzzle, signed
  localparam int AW   = 49;          // |V|^2 - s^2, signed
  localparam int AMW  = AW - 1;      // magnitude of the leading term
  localparam int HW   = 58;          // R.V, signed
  localparam int HMW  = HW - 1;      // magnitude of R.V
  localparam int CW   = 66;          // |R|^2, unsigned
  localparam int SW   = 58;          // square root result bits
  localparam int DW   = 2 * SW;      // discriminant bits
  localparam int NSW  = 60;          // candidate numerators, signed
  localparam int FRAC = 16;          // time fraction bits
  localparam int NW   = CW + FRAC;   // dividend bits
  localparam int VDW  = 59;          // divisor bits
  localparam int QW   = 32;          // quotient bits
  localparam int XW   = VDW + QW;    // compare width inside the divider
  localparam int PW   = QW + 1 + 24; // time times velocity product

  // Result status codes
  localparam logic STATUS_HIT      = 1'b0;
  localparam logic STATUS_FALLBACK = 1'b1;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic signed [31:0] muzzle_x;
    logic signed [31:0] muzzle_y;
    logic signed [31:0] muzzle_z;
    logic        [22:0] projectile_speed;
  } tip_item_t;

  typedef struct packed {
    logic signed [31:0] pred_x;
    logic signed [31:0] pred_y;
    logic signed [31:0] pred_z;
    logic        [31:0] hit_time;
    logic               status;
  } tip_result_t;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
  } tip_geo_t;

  // Square root cell payload: remainder and partial root
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [SW-1:0] root;
  } tip_sq_t;

  // Divider cell payload: remainder, divisor, partial quotient
  typedef struct packed {
    logic [NW-1:0]  rem;
    logic [VDW-1:0] dvs;
    logic [QW-1:0]  q;
  } tip_div_t;

  // Data that rides alongside the square root chain
  typedef struct packed {
    tip_geo_t              geo;
    logic                  a_zero;
    logic                  a_neg;
    logic signed [HW-1:0]  h;
    logic        [CW-1:0]  c;
    logic        [AMW-1:0] am;
    logic                  real_d;
  } tip_sq_side_t;

  // Data that rides alongside the divider chain
  typedef struct packed {
    tip_geo_t geo;
    logic     ok;
    logic     zero_t;
    logic     sat;
  } tip_dv_side_t;

endpackage

### hdl/target_intercept_predictor.sv
// Intercept predictor top level: front products, root and divider cell rows, aim stage.
//
// Fully pipelined lead predictor: one item is taken every cycle while the output is not
// stalled. It passes six front stages for the products and discriminant, a row of 58
// square root cells at one root bit each, two stages that pick the root and check for
// time overflow, a row of 32 divider cells at one quotient bit each, one stage for the
// time-times-velocity products and the output register. The whole pipeline holds
// while a waiting result is stalled; bubbles cost nothing otherwise. Times are Q16.16
// and saturate to all ones; aim points saturate to the 32-bit range. When no
// non-negative intercept exists the target position comes back with hit_time zero and
// status set.
module target_intercept_predictor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  tip_pkg::tip_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output tip_pkg::tip_result_t result
);
  import tip_pkg::*;

  function automatic logic [31:0] mag33(input logic signed [RW-1:0] v);
    logic [RW-1:0] m;
    m = v[RW-1] ? RW'(-v) : v;
    return m[RW-2:0];
  endfunction

  // target plus floor(p / 2^16), saturated
  function automatic logic [31:0] aim(input logic signed [31:0] tgt,
                                      input logic signed [PW-1:0] p);
    logic signed [PW-1:0]      shr;
    logic signed [PW-FRAC:0]   sum;
    shr = p >>> FRAC;
    sum = (PW-FRAC+1)'(tgt) + (PW-FRAC+1)'($signed(shr[PW-FRAC-1:0]));
    if (sum[PW-FRAC:31] != {(PW-FRAC-30){sum[31]}}) begin
      return sum[PW-FRAC] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return sum[31:0];
  endfunction

  logic en;

  // Advance when the output register is empty or being taken
  assign en         = !result_valid || !result_stall;
  assign item_stall = !en;

  // Stage registers
  logic                  s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s7_vld, s9_vld;
  tip_geo_t              s1_geo, s2_geo, s3_geo;
  logic signed [RW-1:0]  s1_rx, s1_ry, s1_rz;
  logic        [22:0]    s1_spd;
  logic signed [47:0]    s2_vxx, s2_vyy, s2_vzz;
  logic        [45:0]    s2_ss;
  logic signed [56:0]    s2_hx, s2_hy, s2_hz;
  logic        [63:0]    s2_cxx, s2_cyy, s2_czz;
  logic signed [AW-1:0]  s3_a;
  logic signed [HW-1:0]  s3_h;
  logic        [CW-1:0]  s3_c;
  tip_sq_side_t          s4_side, s5_side;
  logic        [49:0]    s4_phh;
  logic        [56:0]    s4_phl;
  logic        [63:0]    s4_pll;
  logic        [63:0]    s4_p00, s4_p01;
  logic        [33:0]    s4_p02;
  logic        [47:0]    s4_p10, s4_p11;
  logic        [17:0]    s4_p12;
  logic        [DW-1:0]  s5_hsq, s5_ac;

  // Square root row
  logic                  sq_in_vld;
  tip_sq_t               sq_in;
  tip_sq_side_t          sq_side_in;
  tip_sq_t               sq_stage [SW];
  tip_sq_side_t          sq_side  [SW];
  logic        [SW-1:0]  sq_vld;

  // Root pick and divider setup
  logic        [NW-1:0]  s7_num;
  logic        [VDW-1:0] s7_dvs;
  tip_dv_side_t          s7_side;

  // Divider row
  logic                  dv_in_vld;
  tip_div_t              dv_in;
  tip_dv_side_t          dv_side_in;
  tip_div_t              dv_stage [QW];
  tip_dv_side_t          dv_side  [QW];
  logic        [QW-1:0]  dv_vld;

  // Aim stage
  logic        [QW-1:0]  s9_t;
  logic signed [PW-1:0]  s9_px, s9_py, s9_pz;
  tip_geo_t              s9_geo;
  logic                  s9_ok;

  // Valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld       <= 1'b0;
      s2_vld       <= 1'b0;
      s3_vld       <= 1'b0;
      s4_vld       <= 1'b0;
      s5_vld       <= 1'b0;
      sq_in_vld    <= 1'b0;
      sq_vld       <= '0;
      s7_vld       <= 1'b0;
      dv_in_vld    <= 1'b0;
      dv_vld       <= '0;
      s9_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      s1_vld       <= item_valid;
      s2_vld       <= s1_vld;
      s3_vld       <= s2_vld;
      s4_vld       <= s3_vld;
      s5_vld       <= s4_vld;
      sq_in_vld    <= s5_vld;
      sq_vld       <= {sq_vld[SW-2:0], sq_in_vld};
      s7_vld       <= sq_vld[SW-1];
      dv_in_vld    <= s7_vld;
      dv_vld       <= {dv_vld[QW-2:0], dv_in_vld};
      s9_vld       <= dv_vld[QW-1];
      result_valid <= s9_vld;
    end
  end

  // Front: relative position, then products, then sums
  always_ff @(posedge clk) begin
    if (en) begin
      s1_geo.tx <= item.target_x;
      s1_geo.ty <= item.target_y;
      s1_geo.tz <= item.target_z;
      s1_geo.vx <= item.vel_x;
      s1_geo.vy <= item.vel_y;
      s1_geo.vz <= item.vel_z;
      s1_rx     <= RW'($signed(item.target_x)) - RW'($signed(item.muzzle_x));
      s1_ry     <= RW'($signed(item.target_y)) - RW'($signed(item.muzzle_y));
      s1_rz     <= RW'($signed(item.target_z)) - RW'($signed(item.muzzle_z));
      s1_spd    <= item.projectile_speed;

      s2_geo <= s1_geo;
      s2_vxx <= $signed(s1_geo.vx) * $signed(s1_geo.vx);
      s2_vyy <= $signed(s1_geo.vy) * $signed(s1_geo.vy);
      s2_vzz <= $signed(s1_geo.vz) * $signed(s1_geo.vz);
      s2_ss  <= s1_spd * s1_spd;
      s2_hx  <= s1_rx * $signed(s1_geo.vx);
      s2_hy  <= s1_ry * $signed(s1_geo.vy);
      s2_hz  <= s1_rz * $signed(s1_geo.vz);
      s2_cxx <= mag33(s1_rx) * mag33(s1_rx);
      s2_cyy <= mag33(s1_ry) * mag33(s1_ry);
      s2_czz <= mag33(s1_rz) * mag33(s1_rz);

      s3_geo <= s2_geo;
      s3_a   <= AW'(s2_vxx) + AW'(s2_vyy) + AW'(s2_vzz) - AW'({1'b0, s2_ss});
      s3_h   <= HW'(s2_hx) + HW'(s2_hy) + HW'(s2_hz);
      s3_c   <= CW'(s2_cxx) + CW'(s2_cyy) + CW'(s2_czz);
    end
  end

  // Magnitudes split into partial products for h^2 and |a|*c
  logic [AW-1:0]  a_abs4;
  logic [HW-1:0]  h_abs4;
  logic [AMW-1:0] am4;
  logic [HMW-1:0] hm4;

  assign a_abs4 = s3_a[AW-1] ? AW'(-s3_a) : s3_a;
  assign h_abs4 = s3_h[HW-1] ? HW'(-s3_h) : s3_h;
  assign am4    = a_abs4[AMW-1:0];
  assign hm4    = h_abs4[HMW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side.geo    <= s3_geo;
      s4_side.a_zero <= (s3_a == '0);
      s4_side.a_neg  <= s3_a[AW-1];
      s4_side.h      <= s3_h;
      s4_side.c      <= s3_c;
      s4_side.am     <= am4;
      s4_side.real_d <= 1'b0;
      s4_phh <= hm4[HMW-1:32] * hm4[HMW-1:32];
      s4_phl <= hm4[HMW-1:32] * hm4[31:0];
      s4_pll <= hm4[31:0] * hm4[31:0];
      s4_p00 <= am4[31:0] * s3_c[31:0];
      s4_p01 <= am4[31:0] * s3_c[63:32];
      s4_p02 <= am4[31:0] * s3_c[CW-1:64];
      s4_p10 <= am4[AMW-1:32] * s3_c[31:0];
      s4_p11 <= am4[AMW-1:32] * s3_c[63:32];
      s4_p12 <= am4[AMW-1:32] * s3_c[CW-1:64];

      s5_side <= s4_side;
      s5_hsq  <= (DW'(s4_phh) << 64) + (DW'(s4_phl) << 33) + DW'(s4_pll);
      s5_ac   <= DW'(s4_p00) + (DW'(s4_p01) << 32) + (DW'(s4_p02) << 64)
               + (DW'(s4_p10) << 32) + (DW'(s4_p11) << 64) + (DW'(s4_p12) << 96);
    end
  end

  // Quarter discriminant, fed into the root row
  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_in.geo    <= s5_side.geo;
      sq_side_in.a_zero <= s5_side.a_zero;
      sq_side_in.a_neg  <= s5_side.a_neg;
      sq_side_in.h      <= s5_side.h;
      sq_side_in.c      <= s5_side.c;
      sq_side_in.am     <= s5_side.am;
      sq_in.root <= '0;
      if (s5_side.a_neg) begin
        sq_in.rem         <= s5_hsq + s5_ac;
        sq_side_in.real_d <= 1'b1;
      end else begin
        sq_in.rem         <= s5_hsq - s5_ac;
        sq_side_in.real_d <= (s5_hsq >= s5_ac);
      end
    end
  end

  // Square root row, most significant bit first
  for (genvar k = 0; k < SW; k++) begin : g_sq
    if (k == 0) begin : g_first
      tip_sqrt_cell #(.BIT(SW - 1 - k)) u_cell (
        .clk (clk), .en (en), .din (sq_in), .dout (sq_stage[k])
      );
    end else begin : g_next
      tip_sqrt_cell #(.BIT(SW - 1 - k)) u_cell (
        .clk (clk), .en (en), .din (sq_stage[k-1]), .dout (sq_stage[k])
      );
    end
  end

  // Carry side data along the root row
  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= sq_side_in;
      for (int k = 1; k < SW; k++) begin
        sq_side[k] <= sq_side[k-1];
      end
    end
  end

  // Pick the smallest non-negative root, or set up the linear solve
  tip_sq_side_t          sd7;
  logic signed [NSW-1:0] nh7, sr7, n1_7, n2_7, n7;
  logic        [NSW-1:0] nm7;
  logic        [HW-1:0]  h_abs7;
  logic                  pick7;
  logic                  ok7, zero7;
  logic        [NW-1:0]  num7;
  logic        [VDW-1:0] dvs7;

  assign sd7    = sq_side[SW-1];
  assign nh7    = -NSW'(sd7.h);
  assign sr7    = $signed({{(NSW-SW){1'b0}}, sq_stage[SW-1].root});
  assign n1_7   = nh7 + sr7;
  assign n2_7   = nh7 - sr7;
  assign h_abs7 = sd7.h[HW-1] ? HW'(-sd7.h) : sd7.h;

  always_comb begin
    pick7 = 1'b0;
    n7    = n1_7;
    if (!sd7.a_neg) begin
      if (!n2_7[NSW-1]) begin
        pick7 = 1'b1;
        n7    = n2_7;
      end else if (!n1_7[NSW-1]) begin
        pick7 = 1'b1;
      end
    end else begin
      if (n1_7[NSW-1] || n1_7 == '0) begin
        pick7 = 1'b1;
      end else if (n2_7[NSW-1] || n2_7 == '0) begin
        pick7 = 1'b1;
        n7    = n2_7;
      end
    end
    nm7 = n7[NSW-1] ? NSW'(-n7) : n7;
    if (sd7.a_zero) begin
      zero7 = (sd7.h == '0) && (sd7.c == '0);
      ok7   = sd7.h[HW-1] || zero7;
      num7  = {sd7.c, {FRAC{1'b0}}};
      dvs7  = VDW'({h_abs7[HMW-1:0], 1'b0});
    end else begin
      zero7 = 1'b0;
      ok7   = sd7.real_d && pick7;
      num7  = NW'({nm7, {FRAC{1'b0}}});
      dvs7  = VDW'(sd7.am);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_num         <= num7;
      s7_dvs         <= dvs7;
      s7_side.geo    <= sd7.geo;
      s7_side.ok     <= ok7;
      s7_side.zero_t <= zero7;
      s7_side.sat    <= 1'b0;
    end
  end

  // Flag a quotient that will not fit, then feed the divider row
  always_ff @(posedge clk) begin
    if (en) begin
      dv_in.rem         <= s7_num;
      dv_in.dvs         <= s7_dvs;
      dv_in.q           <= '0;
      dv_side_in.geo    <= s7_side.geo;
      dv_side_in.ok     <= s7_side.ok;
      dv_side_in.zero_t <= s7_side.zero_t;
      dv_side_in.sat    <= (XW'(s7_num) >= (XW'(s7_dvs) << QW));
    end
  end

  // Divider row, most significant quotient bit first
  for (genvar k = 0; k < QW; k++) begin : g_dv
    if (k == 0) begin : g_first
      tip_div_cell #(.BIT(QW - 1 - k)) u_cell (
        .clk (clk), .en (en), .din (dv_in), .dout (dv_stage[k])
      );
    end else begin : g_next
      tip_div_cell #(.BIT(QW - 1 - k)) u_cell (
        .clk (clk), .en (en), .din (dv_stage[k-1]), .dout (dv_stage[k])
      );
    end
  end

  // Carry side data along the divider row
  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= dv_side_in;
      for (int k = 1; k < QW; k++) begin
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  // Final time and velocity offsets
  tip_dv_side_t    sd9;
  logic [QW-1:0]   t9;

  assign sd9 = dv_side[QW-1];
  assign t9  = sd9.zero_t ? '0 : (sd9.sat ? '1 : dv_stage[QW-1].q);

  always_ff @(posedge clk) begin
    if (en) begin
      s9_t   <= t9;
      s9_geo <= sd9.geo;
      s9_ok  <= sd9.ok;
      s9_px  <= $signed({1'b0, t9}) * $signed(sd9.geo.vx);
      s9_py  <= $signed({1'b0, t9}) * $signed(sd9.geo.vy);
      s9_pz  <= $signed({1'b0, t9}) * $signed(sd9.geo.vz);
    end
  end

  // Output register: aim point or fallback
  always_ff @(posedge clk) begin
    if (en) begin
      if (s9_ok) begin
        result.pred_x   <= aim(s9_geo.tx, s9_px);
        result.pred_y   <= aim(s9_geo.ty, s9_py);
        result.pred_z   <= aim(s9_geo.tz, s9_pz);
        result.hit_time <= s9_t;
        result.status   <= STATUS_HIT;
      end else begin
        result.pred_x   <= s9_geo.tx;
        result.pred_y   <= s9_geo.ty;
        result.pred_z   <= s9_geo.tz;
        result.hit_time <= '0;
        result.status   <= STATUS_FALLBACK;
      end
    end
  end

endmodule

### hdl/tip_sqrt_cell.sv
// One restoring square root cell: decides one root bit per beat while enabled.
module tip_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  tip_pkg::tip_sq_t din,
  output tip_pkg::tip_sq_t dout
);
  import tip_pkg::*;

  logic [DW-1:0] trial;
  logic          take;

  // (root + 2^BIT)^2 - root^2, root holding only bits above BIT
  assign trial = ({{(DW-SW){1'b0}}, din.root} << (BIT + 1))
               | ({{(DW-1){1'b0}}, 1'b1} << (2 * BIT));
  assign take  = (din.rem >= trial);

  // Advance remainder and root to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem  <= take ? (din.rem - trial) : din.rem;
      dout.root <= din.root | (take ? (SW'(1) << BIT) : {SW{1'b0}});
    end
  end

endmodule

### hdl/tip_div_cell.sv
// One restoring divider cell: decides one quotient bit per beat while enabled.
module tip_div_cell #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              en,
  input  tip_pkg::tip_div_t din,
  output tip_pkg::tip_div_t dout
);
  import tip_pkg::*;

  logic [XW-1:0] rem_x;
  logic [XW-1:0] sub;
  logic [XW-1:0] diff;
  logic          take;

  assign rem_x = XW'(din.rem);
  assign sub   = XW'(din.dvs) << BIT;
  assign diff  = rem_x - sub;
  assign take  = (rem_x >= sub);

  // Advance remainder, divisor and quotient to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem <= take ? diff[NW-1:0] : din.rem;
      dout.dvs <= din.dvs;
      dout.q   <= din.q | (take ? (QW'(1) << BIT) : {QW{1'b0}});
    end
  end

endmodule
